@@ rtl/core/tcmic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcmic_pkg
// Shared types and constants of the three-class masked interrupt controller.
// ----------------------------------------------------------------------------
package tcmic_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned N_LEVELS = 3;
    localparam int unsigned N_MASKS  = 9;
    localparam int unsigned MASK_IW  = $clog2(N_MASKS);

    localparam logic [WORD_W-1:0] NRM_LOW_BITS = 32'h3FFF_FFFF;
    localparam logic [WORD_W-1:0] EXT_SUMMARY  = 32'h4000_0000;
    localparam logic [WORD_W-1:0] ERR_SUMMARY  = 32'h8000_0000;

    typedef enum logic [1:0] {
        FN_RAISE  = 2'd0,
        FN_CANCEL = 2'd1,
        FN_WRITE  = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    localparam logic [1:0] CL_NORMAL   = 2'd0;
    localparam logic [1:0] CL_EXTERNAL = 2'd1;
    localparam logic [1:0] CL_ERROR    = 2'd2;

    localparam logic [3:0] SEL_NORMAL    = 4'd0;
    localparam logic [3:0] SEL_EXTERNAL  = 4'd1;
    localparam logic [3:0] SEL_ERROR     = 4'd2;
    localparam logic [3:0] SEL_MASK_LO   = 4'd3;
    localparam logic [3:0] SEL_MASK_HI   = 4'd11;

    typedef struct packed {
        t_func             func;
        logic [1:0]        irq_class;
        logic [4:0]        irq_bit;
        logic [3:0]        reg_sel;
        logic [WORD_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              level6_pending;
        logic              level4_pending;
        logic              level2_pending;
    } t_result;

endpackage : tcmic_pkg
`default_nettype wire

@@ rtl/core/three_class_masked_interrupt_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// three_class_masked_interrupt_controller
// Each input beat raises or cancels one status bit, writes or reads one
// register, and returns exactly one result beat carrying the read word and
// the three level lines as they stand after the beat. The block takes one
// beat per cycle while the output side does not stall; a result passes
// from the input register through the single update stage into the result
// register, where it waits while the output side stalls. Nothing is lost
// while the result register waits: the input register holds one more beat.
// ----------------------------------------------------------------------------
module three_class_masked_interrupt_controller
    import tcmic_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [1:0]        i_irq_class,
    input  wire logic [4:0]        i_irq_bit,
    input  wire logic [3:0]        i_reg_sel,
    input  wire logic [WORD_W-1:0] i_write_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [WORD_W-1:0]      o_read_data,
    output logic                   o_level6_pending,
    output logic                   o_level4_pending,
    output logic                   o_level2_pending
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result upd_result;
    logic    out_free;
    logic    advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    tcmic_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (upd_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.func       <= t_func'(i_func);
            r_in.irq_class  <= i_irq_class;
            r_in.irq_bit    <= i_irq_bit;
            r_in.reg_sel    <= i_reg_sel;
            r_in.write_data <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= upd_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_out.read_data;
    assign o_level6_pending = r_out.level6_pending;
    assign o_level4_pending = r_out.level4_pending;
    assign o_level2_pending = r_out.level2_pending;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("pending input beat overwritten");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("update stage result dropped");

endmodule : three_class_masked_interrupt_controller
`default_nettype wire

@@ rtl/core/tcmic_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcmic_regs
// Status and mask registers, their update for one beat, read mux and the
// level line reduction taken from the updated state.
// ----------------------------------------------------------------------------
module tcmic_regs
    import tcmic_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    output t_result      o_result
);

    logic [WORD_W-1:0] r_normal,   n_normal;
    logic [WORD_W-1:0] r_external, n_external;
    logic [WORD_W-1:0] r_error,    n_error;
    logic [WORD_W-1:0] r_mask [N_MASKS];
    logic [WORD_W-1:0] n_mask [N_MASKS];

    logic [WORD_W-1:0] bit_word;
    logic [3:0]        sel_off;
    logic [MASK_IW-1:0] mask_idx;
    logic              sel_is_mask;
    logic [WORD_W-1:0] rd;
    logic [N_LEVELS-1:0] lvl;

    assign bit_word    = WORD_W'(1) << i_item.irq_bit;
    assign sel_off     = i_item.reg_sel - SEL_MASK_LO;
    assign mask_idx    = sel_off[MASK_IW-1:0];
    assign sel_is_mask = (i_item.reg_sel >= SEL_MASK_LO) && (i_item.reg_sel <= SEL_MASK_HI);

    always_comb begin
        n_normal   = r_normal;
        n_external = r_external;
        n_error    = r_error;
        n_mask     = r_mask;
        rd         = '0;
        unique case (i_item.func)
            FN_RAISE: begin
                if (i_item.irq_class == CL_NORMAL)   n_normal   = r_normal   | bit_word;
                if (i_item.irq_class == CL_EXTERNAL) n_external = r_external | bit_word;
                if (i_item.irq_class == CL_ERROR)    n_error    = r_error    | bit_word;
            end
            FN_CANCEL: begin
                if (i_item.irq_class == CL_NORMAL)   n_normal   = r_normal   & ~bit_word;
                if (i_item.irq_class == CL_EXTERNAL) n_external = r_external & ~bit_word;
                if (i_item.irq_class == CL_ERROR)    n_error    = r_error    & ~bit_word;
            end
            FN_WRITE: begin
                if (i_item.reg_sel == SEL_NORMAL) n_normal = r_normal & ~i_item.write_data;
                if (i_item.reg_sel == SEL_ERROR)  n_error  = r_error  & ~i_item.write_data;
                if (sel_is_mask) n_mask[mask_idx] = i_item.write_data;
            end
            FN_READ: begin
                if (i_item.reg_sel == SEL_NORMAL) begin
                    rd = r_normal & NRM_LOW_BITS;
                    if (r_external != '0) rd = rd | EXT_SUMMARY;
                    if (r_error != '0)    rd = rd | ERR_SUMMARY;
                end
                if (i_item.reg_sel == SEL_EXTERNAL) rd = r_external;
                if (i_item.reg_sel == SEL_ERROR)    rd = r_error;
                if (sel_is_mask) rd = r_mask[mask_idx];
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int l = 0; l < N_LEVELS; l++) begin
            lvl[l] = |((n_normal   & n_mask[l])
                     | (n_external & n_mask[N_LEVELS + l])
                     | (n_error    & n_mask[2*N_LEVELS + l]));
        end
    end

    assign o_result = {rd, lvl[0], lvl[1], lvl[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal   <= '0;
            r_external <= '0;
            r_error    <= '0;
            for (int m = 0; m < N_MASKS; m++) r_mask[m] <= '0;
        end else if (i_fire) begin
            r_normal   <= n_normal;
            r_external <= n_external;
            r_error    <= n_error;
            r_mask     <= n_mask;
        end
    end

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_normal == '0) && (r_external == '0) && (r_error == '0))
        else $error("status not cleared by reset");

    a_raise_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.func == FN_RAISE) && (i_item.irq_class == CL_NORMAL)
        |=> r_normal[$past(i_item.irq_bit)])
        else $error("raised normal bit not set");

    a_ext_write_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.func == FN_WRITE) && (i_item.reg_sel == SEL_EXTERNAL)
        |=> $stable(r_external))
        else $error("external status changed by a write");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_normal) && $stable(r_error))
        else $error("status changed without a beat");

endmodule : tcmic_regs
`default_nettype wire
